FILE: src/ckset_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckset_pkg
// Shared types and constants for the counted key set register.
// ----------------------------------------------------------------------------
package ckset_pkg;

   localparam int KEYS           = 128;
   localparam int COUNT_WIDTH    = 16;
   localparam int VALUE_WIDTH    = 16;
   localparam int CMD_WIDTH      = 3;
   localparam int BITS_PER_WORD  = 64;
   localparam int WORDS          = KEYS / BITS_PER_WORD;
   localparam int KEY_WIDTH      = $clog2(KEYS);
   localparam int WORD_CNT_WIDTH = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Register index, taken from the word address of the CSR port.
   localparam logic REG_DECREMENT_MODE = 1'b0;

   typedef enum logic [CMD_WIDTH-1:0] {
      OP_SET_ACTION  = 3'd0,
      OP_UPDATE      = 3'd1,
      OP_UPDATE_DUMP = 3'd2,
      OP_DUMP        = 3'd3,
      OP_CLEAR       = 3'd4
   } ckset_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_UPDATE_DUMP,
      ST_DUMP
   } ckset_state_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]          cmd;
      logic signed [VALUE_WIDTH-1:0] value;
   } ckset_req_type;

   typedef struct packed {
      logic                     word_index;
      logic [BITS_PER_WORD-1:0] occupied_bits;
      logic                     set_empty;
      logic                     last;
   } ckset_rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic set_action;
      logic clear_all;
      logic read_key;
      logic write_back;
      logic load_word;
   } ckset_ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic [CMD_WIDTH-1:0] cmd;
      logic                 key_ok;
      logic                 slot_free;
      logic                 word_last;
   } ckset_status_type;

endpackage

FILE: src/ckset_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckset_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ckset_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: src/ckset_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckset_ctrl
// Sequencer: takes one word at a time, runs set action, clear, counter updates and dumps.
// ----------------------------------------------------------------------------
module ckset_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire ckset_pkg::ckset_status_type status,
   output logic                            req_stall,
   output ckset_pkg::ckset_ctl_type        ctl
);

   ckset_pkg::ckset_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ckset_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = (state_ff != ckset_pkg::ST_IDLE);
      case (state_ff)
         ckset_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               case (status.cmd)
                  ckset_pkg::OP_SET_ACTION: begin
                     ctl.set_action = status.key_ok;
                  end
                  ckset_pkg::OP_UPDATE: begin
                     if (status.key_ok) begin
                        ctl.read_key = 1'b1;
                        state_in     = ckset_pkg::ST_UPDATE;
                     end
                  end
                  ckset_pkg::OP_UPDATE_DUMP: begin
                     ctl.read_key = status.key_ok;
                     state_in     = status.key_ok ? ckset_pkg::ST_UPDATE_DUMP
                                                  : ckset_pkg::ST_DUMP;
                  end
                  ckset_pkg::OP_DUMP: begin
                     state_in = ckset_pkg::ST_DUMP;
                  end
                  ckset_pkg::OP_CLEAR: begin
                     ctl.clear_all = 1'b1;
                  end
                  default: begin
                     // unused codes: drop
                  end
               endcase
            end
         end
         ckset_pkg::ST_UPDATE: begin
            ctl.write_back = 1'b1;
            state_in       = ckset_pkg::ST_IDLE;
         end
         ckset_pkg::ST_UPDATE_DUMP: begin
            ctl.write_back = 1'b1;
            state_in       = ckset_pkg::ST_DUMP;
         end
         ckset_pkg::ST_DUMP: begin
            if (status.slot_free) begin
               ctl.load_word = 1'b1;
               if (status.word_last) begin
                  state_in = ckset_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ckset_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: src/ckset_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckset_dp
// Datapath: count RAM, valid and occupancy flags, dump output register.
// ----------------------------------------------------------------------------
module ckset_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ckset_pkg::ckset_req_type   req_data,
   input  wire logic                       decrement_mode,
   input  wire ckset_pkg::ckset_ctl_type   ctl,
   output ckset_pkg::ckset_status_type     status,
   input  wire logic                       rsp_stall,
   output logic                            rsp_valid,
   output ckset_pkg::ckset_rsp_type        rsp_data
);

   logic                                     store_action_ff, store_action_in;
   logic [ckset_pkg::KEY_WIDTH-1:0]          key_ff, key_in;
   logic [ckset_pkg::KEYS-1:0]               valid_ff, valid_in;
   logic [ckset_pkg::KEYS-1:0]               occupied_ff, occupied_in;
   logic [ckset_pkg::WORD_CNT_WIDTH-1:0]     word_ff, word_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   ckset_pkg::ckset_rsp_type                 rsp_data_ff, rsp_data_in;

   logic [ckset_pkg::COUNT_WIDTH-1:0]        ram_rdata;
   logic [ckset_pkg::COUNT_WIDTH-1:0]        count_cur;
   logic [ckset_pkg::COUNT_WIDTH-1:0]        count_new;
   logic                                     key_ok;
   logic                                     word_last;

   ckset_ram #(
      .WIDTH (ckset_pkg::COUNT_WIDTH),
      .DEPTH (ckset_pkg::KEYS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ctl.write_back),
      .wr_addr (key_ff),
      .wr_data (count_new),
      .rd_en   (ctl.read_key),
      .rd_addr (key_in),
      .rd_data (ram_rdata)
   );

   // Key in range: sign clear and magnitude below the key count.
   assign key_ok = !req_data.value[ckset_pkg::VALUE_WIDTH-1]
                   && (req_data.value[ckset_pkg::VALUE_WIDTH-2:0]
                       < (ckset_pkg::VALUE_WIDTH-1)'(ckset_pkg::KEYS));
   assign key_in    = req_data.value[ckset_pkg::KEY_WIDTH-1:0];
   assign word_last = (word_ff == ckset_pkg::WORD_CNT_WIDTH'(ckset_pkg::WORDS - 1));

   // An entry never written since reset or clear reads as zero.
   assign count_cur = valid_ff[key_ff] ? ram_rdata : '0;

   always_comb begin
      if (store_action_ff) begin
         count_new = (count_cur == ckset_pkg::COUNT_MAX) ? count_cur
                                                         : count_cur + 1'b1;
      end else if (decrement_mode) begin
         count_new = (count_cur == '0) ? count_cur : count_cur - 1'b1;
      end else begin
         count_new = '0;
      end
   end

   always_comb begin
      store_action_in = store_action_ff;
      if (ctl.set_action) begin
         store_action_in = (req_data.value != '0);
      end

      valid_in    = valid_ff;
      occupied_in = occupied_ff;
      if (ctl.clear_all) begin
         valid_in    = '0;
         occupied_in = '0;
      end else if (ctl.write_back) begin
         valid_in[key_ff]    = 1'b1;
         occupied_in[key_ff] = (count_new != '0);
      end

      word_in     = word_ff;
      rsp_data_in = rsp_data_ff;
      if (ctl.load_word) begin
         word_in                   = word_last ? '0 : word_ff + 1'b1;
         rsp_data_in.word_index    = word_ff[0];
         rsp_data_in.occupied_bits =
            occupied_ff[word_ff * ckset_pkg::BITS_PER_WORD +: ckset_pkg::BITS_PER_WORD];
         rsp_data_in.set_empty     = ~|occupied_ff;
         rsp_data_in.last          = word_last;
      end

      rsp_valid_in = ctl.load_word | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_action_ff <= 1'b0;
         valid_ff        <= '0;
         occupied_ff     <= '0;
         word_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         store_action_ff <= store_action_in;
         valid_ff        <= valid_in;
         occupied_ff     <= occupied_in;
         word_ff         <= word_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      if (ctl.accept) begin
         key_ff <= key_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign status.cmd       = req_data.cmd;
   assign status.key_ok    = key_ok;
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign status.word_last = word_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: src/counted_key_set_register.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counted_key_set_register
// Set of 128 keys with saturating 16-bit use counts and occupancy dump.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one command word (cmd, value) at a time; the block
//   stalls it while a word is in progress. In an update the count is read
//   from the count RAM in the accept cycle and written back in the next one,
//   so the RAM read latency sets the update rate. A dump loads one rsp_ word
//   per 64-key group (two words, lowest keys first, last on the final one),
//   one per cycle while the receiver does not stall: the sequencer moves to
//   its dump state after the accept (through the update write-back first for
//   update-then-dump) and loads each word there into the output register.
//   rsp_ words pass through one output register: a new command is taken
//   while the final dump word still waits there, and a stalled receiver
//   holds the dump in place until the register frees up.
//   Reset clears all counts (through per-key valid flags, no RAM sweep),
//   the store action flag and decrement_mode. A clear command empties the
//   set and gives no output word.
//   decrement_mode sits at CSR byte address 0; write it only while idle.
// ----------------------------------------------------------------------------
module counted_key_set_register (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // command channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire ckset_pkg::ckset_req_type              req_data,
   // dump word channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output ckset_pkg::ckset_rsp_type                   rsp_data,
   // register port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [ckset_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [ckset_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [ckset_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                       pready
);

   logic                        decrement_mode_ff, decrement_mode_in;
   logic                        csr_write;
   logic                        csr_index;
   ckset_pkg::ckset_ctl_type    ctl;
   ckset_pkg::ckset_status_type status;

   // Register index is the word address; byte offset bits are ignored.
   assign csr_index = paddr[ckset_pkg::CSR_ADDR_WIDTH-1];
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      decrement_mode_in = decrement_mode_ff;
      if (csr_write && (csr_index == ckset_pkg::REG_DECREMENT_MODE)) begin
         decrement_mode_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == ckset_pkg::REG_DECREMENT_MODE) begin
         prdata[0] = decrement_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decrement_mode_ff <= 1'b0;
      end else begin
         decrement_mode_ff <= decrement_mode_in;
      end
   end

   // Sequencer: decides per command word which datapath steps run.
   ckset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   // Counts, occupancy flags and the output register.
   ckset_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .decrement_mode (decrement_mode_ff),
      .ctl            (ctl),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire
